[rtl/core/size_class_bitmap_slab_allocator_assert.svh]
// Assertion macros for the slab allocator core.
// Relies on clk_i and rst_ni being visible in the module that includes it.
`ifndef SIZE_CLASS_BITMAP_SLAB_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_BITMAP_SLAB_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define SCBSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCBSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/scbsa_pkg.sv]
// Shared types and constants for the slab allocator core.
// No dependencies.
package scbsa_pkg;

  localparam int unsigned MEM_WORD_W = 32;
  localparam int unsigned WORD_IDX_W = 6;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_TOO_LARGE   = 3'd1,
    STAT_NO_PAGE     = 3'd2,
    STAT_BAD_HANDLE  = 3'd3,
    STAT_DOUBLE_FREE = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [3:0]  cls;
    logic [1:0]  page;
    logic [9:0]  slot;
    logic [11:0] offset;
    logic        released;
  } res_t;

endpackage

[rtl/core/scbsa_bitmap_mem.sv]
// Bitmap word store: one write port, one read port, registered read data.
// Depends on scbsa_pkg for the word width.
module scbsa_bitmap_mem #(
  parameter int unsigned DEPTH = 1152,
  parameter int unsigned AW    = 11
) (
  input  logic                              clk_i,
  input  logic                              re_i,
  input  logic [AW-1:0]                     raddr_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic [scbsa_pkg::MEM_WORD_W-1:0]  wdata_i,
  output logic [scbsa_pkg::MEM_WORD_W-1:0]  rdata_o
);
  import scbsa_pkg::*;

  logic [MEM_WORD_W-1:0] mem [DEPTH];
  logic [MEM_WORD_W-1:0] rdata_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/size_class_bitmap_slab_allocator.sv]
// Slab allocator core: a decode state, then at most one bitmap memory access per cycle.
// Allocate passes over inactive pages and scans each bitmap word of active ones, or
// fills every word of a fresh page; free updates the slot's word, then checks the page's words.
// The result waits in ST_OUT for the output register; one command is in progress at a time.
// Reset clears all page-active bits; bitmap words are written when a page is activated.
module size_class_bitmap_slab_allocator #(
  parameter int unsigned NUM_CLASSES     = 9,
  parameter int unsigned PAGES_PER_CLASS = 4,
  parameter int unsigned PAGE_BYTES      = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [15:0] request_bytes_i,
  input  logic [3:0]  free_class_i,
  input  logic [1:0]  free_page_i,
  input  logic [9:0]  free_slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  class_out_o,
  output logic [1:0]  page_out_o,
  output logic [9:0]  slot_out_o,
  output logic [11:0] byte_offset_o,
  output logic        page_released_o
);
  import scbsa_pkg::*;

  localparam int unsigned WPP   = PAGE_BYTES / 128;
  localparam int unsigned NPG   = NUM_CLASSES * PAGES_PER_CLASS;
  localparam int unsigned DEPTH = NPG * WPP;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PGW   = (NPG > 1) ? $clog2(NPG) : 1;
  localparam int unsigned PCW   = $clog2(PAGES_PER_CLASS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEC, ST_A_SEEK, ST_A_WAIT, ST_A_FILL,
    ST_F_WAIT, ST_F_SCAN, ST_F_CHK, ST_OUT
  } state_e;

  state_e                state_q, state_d;
  logic                  cmd_q, cmd_d;
  logic [3:0]            cls_q, cls_d;
  logic [PCW-1:0]        page_q, page_d;
  logic [1:0]            epage_q, epage_d;
  logic [9:0]            slot_q, slot_d;
  logic                  bad_q, bad_d;
  logic [WORD_IDX_W-1:0] w_q, w_d;
  logic [NPG-1:0]        active_q, active_d;
  res_t                  res_q, res_d;
  res_t                  out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  mem_re, mem_we;
  logic [AW-1:0]         mem_raddr, mem_waddr;
  logic [MEM_WORD_W-1:0] mem_wdata, mem_rdata;

  logic [4:0]            sh_c;
  logic [13:0]           raw_c;
  logic [WORD_IDX_W-1:0] words_c;
  logic [10:0]           nslots_c;
  logic [PGW-1:0]        pg_c;

  // Mask of the slots that exist within bitmap word w.
  function automatic logic [MEM_WORD_W-1:0] vmask(logic [10:0] ns,
                                                  logic [WORD_IDX_W-1:0] w);
    logic [11:0] lo;
    logic [11:0] d;
    lo = {1'b0, w, 5'b0};
    d  = {1'b0, ns} - lo;
    if ({1'b0, ns} >= lo + 12'd32) begin
      return '1;
    end else if ({1'b0, ns} <= lo) begin
      return '0;
    end
    return (32'd1 << d[4:0]) - 32'd1;
  endfunction

  // Offset of a slot's data: bitmap words first, then slots of 4<<c bytes.
  function automatic logic [11:0] boff(logic [WORD_IDX_W-1:0] words, logic [9:0] s,
                                       logic [4:0] sh);
    logic [23:0] t;
    t = (24'(s) << sh) + (24'(words) << 2);
    return t[11:0];
  endfunction

  function automatic logic [AW-1:0] maddr(logic [PGW-1:0] pg, logic [WORD_IDX_W-1:0] w);
    return AW'(int'(pg) * WPP + int'(w));
  endfunction

  // Class geometry from the held class.
  always_comb begin
    sh_c     = {1'b0, cls_q} + 5'd2;
    raw_c    = 14'(PAGE_BYTES) >> sh_c;
    words_c  = WORD_IDX_W'((raw_c + 14'd31) >> 5);
    nslots_c = 11'((14'(PAGE_BYTES) - {6'b0, words_c, 2'b00}) >> sh_c);
    pg_c     = PGW'(int'(cls_q) * PAGES_PER_CLASS + int'(page_q));
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Command sequencer.
  always_comb begin
    logic                  hit;
    logic [3:0]            pick;
    logic                  fnd;
    logic [PCW-1:0]        fp;
    logic [MEM_WORD_W-1:0] m;
    logic [MEM_WORD_W-1:0] vm;
    logic [MEM_WORD_W-1:0] bitv;
    logic [4:0]            b;
    logic [9:0]            s;

    state_d     = state_q;
    cmd_d       = cmd_q;
    cls_d       = cls_q;
    page_d      = page_q;
    epage_d     = epage_q;
    slot_d      = slot_q;
    bad_d       = bad_q;
    w_d         = w_q;
    active_d    = active_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_re      = 1'b0;
    mem_raddr   = maddr(pg_c, w_q);
    mem_we      = 1'b0;
    mem_waddr   = maddr(pg_c, w_q);
    mem_wdata   = '0;
    hit         = 1'b0;
    pick        = '0;
    fnd         = 1'b0;
    fp          = '0;
    vm          = vmask(nslots_c, w_q);
    m           = mem_rdata & vm;
    bitv        = 32'd1 << slot_q[4:0];
    b           = '0;
    s           = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d = command_i;
          if (command_i == CMD_ALLOC) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
              if (!hit && ({1'b0, request_bytes_i} <= (17'd4 << i))) begin
                hit  = 1'b1;
                pick = 4'(i);
              end
            end
            cls_d  = pick;
            page_d = '0;
            w_d    = '0;
            if (hit) begin
              state_d = ST_DEC;
            end else begin
              res_d   = '{STAT_TOO_LARGE, 4'd0, 2'd0, 10'd0, 12'd0, 1'b0};
              state_d = ST_OUT;
            end
          end else begin
            cls_d   = free_class_i;
            epage_d = free_page_i;
            page_d  = PCW'(free_page_i);
            slot_d  = free_slot_i;
            bad_d   = (int'(free_class_i) >= NUM_CLASSES) ||
                      (int'(free_page_i) >= PAGES_PER_CLASS);
            state_d = ST_DEC;
          end
        end
      end

      ST_DEC: begin
        if (cmd_q == CMD_ALLOC) begin
          if (nslots_c == 11'd0) begin
            res_d   = '{STAT_NO_PAGE, cls_q, 2'd0, 10'd0, 12'd0, 1'b0};
            state_d = ST_OUT;
          end else begin
            state_d = ST_A_SEEK;
          end
        end else begin
          if (bad_q || !active_q[pg_c] || ({1'b0, slot_q} >= nslots_c)) begin
            res_d   = '{STAT_BAD_HANDLE, cls_q, epage_q, slot_q, 12'd0, 1'b0};
            state_d = ST_OUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = maddr(pg_c, {1'b0, slot_q[9:5]});
            state_d   = ST_F_WAIT;
          end
        end
      end

      // Walk the class's pages; read one bitmap word of an active page, or activate a free page once all are walked.
      ST_A_SEEK: begin
        if (page_q == PCW'(PAGES_PER_CLASS)) begin
          for (int p = 0; p < PAGES_PER_CLASS; p++) begin
            if (!fnd && !active_q[PGW'(int'(cls_q) * PAGES_PER_CLASS + p)]) begin
              fnd = 1'b1;
              fp  = PCW'(p);
            end
          end
          if (fnd) begin
            page_d  = fp;
            w_d     = '0;
            active_d[PGW'(int'(cls_q) * PAGES_PER_CLASS + int'(fp))] = 1'b1;
            state_d = ST_A_FILL;
          end else begin
            res_d   = '{STAT_NO_PAGE, cls_q, 2'd0, 10'd0, 12'd0, 1'b0};
            state_d = ST_OUT;
          end
        end else if (!active_q[pg_c]) begin
          page_d = page_q + PCW'(1);
        end else begin
          mem_re  = 1'b1;
          state_d = ST_A_WAIT;
        end
      end

      // Take the lowest free slot of the word, or move on.
      ST_A_WAIT: begin
        if (m != '0) begin
          for (int i = MEM_WORD_W - 1; i >= 0; i--) begin
            if (m[i]) begin
              b = 5'(i);
            end
          end
          s         = {w_q[4:0], b};
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~(32'd1 << b);
          res_d     = '{STAT_OK, cls_q, 2'(page_q), s, boff(words_c, s, sh_c), 1'b0};
          state_d   = ST_OUT;
        end else begin
          if (w_q == words_c - WORD_IDX_W'(1)) begin
            w_d    = '0;
            page_d = page_q + PCW'(1);
          end else begin
            w_d = w_q + WORD_IDX_W'(1);
          end
          state_d = ST_A_SEEK;
        end
      end

      // Fresh page: all slots free except slot 0, which is handed out.
      ST_A_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = (w_q == '0) ? ~32'd1 : '1;
        if (w_q == words_c - WORD_IDX_W'(1)) begin
          res_d   = '{STAT_OK, cls_q, 2'(page_q), 10'd0, boff(words_c, 10'd0, sh_c), 1'b0};
          state_d = ST_OUT;
        end else begin
          w_d = w_q + WORD_IDX_W'(1);
        end
      end

      ST_F_WAIT: begin
        if ((mem_rdata & bitv) != '0) begin
          res_d   = '{STAT_DOUBLE_FREE, cls_q, epage_q, slot_q, 12'd0, 1'b0};
          state_d = ST_OUT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = maddr(pg_c, {1'b0, slot_q[9:5]});
          mem_wdata = mem_rdata | bitv;
          w_d       = '0;
          state_d   = ST_F_SCAN;
        end
      end

      ST_F_SCAN: begin
        mem_re  = 1'b1;
        state_d = ST_F_CHK;
      end

      // Check whether every slot of the page is now free.
      ST_F_CHK: begin
        if ((mem_rdata & vm) != vm) begin
          res_d   = '{STAT_OK, cls_q, epage_q, slot_q, boff(words_c, slot_q, sh_c), 1'b0};
          state_d = ST_OUT;
        end else if (w_q == words_c - WORD_IDX_W'(1)) begin
          active_d[pg_c] = 1'b0;
          res_d   = '{STAT_OK, cls_q, epage_q, slot_q, boff(words_c, slot_q, sh_c), 1'b1};
          state_d = ST_OUT;
        end else begin
          w_d     = w_q + WORD_IDX_W'(1);
          state_d = ST_F_SCAN;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_ALLOC;
      cls_q       <= '0;
      page_q      <= '0;
      epage_q     <= '0;
      slot_q      <= '0;
      bad_q       <= 1'b0;
      w_q         <= '0;
      active_q    <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      cls_q       <= cls_d;
      page_q      <= page_d;
      epage_q     <= epage_d;
      slot_q      <= slot_d;
      bad_q       <= bad_d;
      w_q         <= w_d;
      active_q    <= active_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  scbsa_bitmap_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign class_out_o     = out_q.cls;
  assign page_out_o      = out_q.page;
  assign slot_out_o      = out_q.slot;
  assign byte_offset_o   = out_q.offset;
  assign page_released_o = out_q.released;

  `include "size_class_bitmap_slab_allocator_assert.svh"

  `SCBSA_ASSERT_IMP(a_wr_states, mem_we,
    (state_q == ST_A_WAIT) || (state_q == ST_A_FILL) || (state_q == ST_F_WAIT),
    "bitmap write outside a writing state")
  `SCBSA_ASSERT_IMP(a_one_bit_toggle,
    mem_we && ((state_q == ST_A_WAIT) || (state_q == ST_F_WAIT)),
    $onehot(mem_rdata ^ mem_wdata), "slot update changed other than one bit")
  `SCBSA_ASSERT_IMP(a_no_rw_clash, mem_re, !mem_we, "bitmap read and write in one cycle")
  `SCBSA_ASSERT_NXT(a_out_load, (state_q == ST_OUT) && !(out_valid_q && out_stall_i),
    out_valid_q && (state_q == ST_IDLE), "result not loaded into output register")

endmodule
